/* rtl/running_median_two_heaps_defines.svh */
// Assertion macros shared by the running median checker.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RMTH_AST_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define RMTH_AST_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers reset itself
`define RMTH_AST_RST(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rmth_pkg.sv */
// Shared types for the two-heap running median.
package rmth_pkg;

  typedef struct packed {
    logic push;
    logic pop;
  } heap_cmd_t;

  typedef enum logic [2:0] {
    H_IDLE,
    H_UP,
    H_PUT,
    H_LAST,
    H_DOWN
  } heap_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_POP,
    S_MOVE,
    S_OUT
  } ctrl_state_t;

endpackage

/* rtl/rmth_heap.sv */
// One binary heap held in a synchronous memory, with push and pop-top sequencing.
module rmth_heap #(
  parameter int W      = 16,
  parameter int DEPTH  = 512,
  parameter bit IS_MAX = 1'b1,
  parameter int CW     = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rmth_pkg::heap_cmd_t     cmd,
  input  logic signed [W-1:0]     cmd_data,
  output logic                    done,
  output logic [CW-1:0]           cnt,
  output logic signed [W-1:0]     top,
  output logic signed [W-1:0]     pop_data
);
  import rmth_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = AW + 2;

  logic [W-1:0] mem [DEPTH];

  heap_state_t        state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic signed [W-1:0] val_r, val_nxt;
  logic signed [W-1:0] top_r, top_nxt;
  logic signed [W-1:0] pop_r, pop_nxt;
  logic signed [W-1:0] rd_a_r, rd_b_r;
  logic [AW-1:0]      rd_a_addr, rd_b_addr;
  logic               we;
  logic [AW-1:0]      wa;
  logic signed [W-1:0] wd;

  logic [AW-1:0]      par, par2;
  logic [XW-1:0]      lch, rch, lch2, rch2, n_x;
  logic               l_win, r_win;
  logic signed [W-1:0] best_v;

  function automatic logic outranks(logic signed [W-1:0] a, logic signed [W-1:0] b);
    outranks = IS_MAX ? (a > b) : (a < b);
  endfunction

  always_comb begin
    par   = (idx_r - AW'(1)) >> 1;
    par2  = (par - AW'(1)) >> 1;
    lch   = (XW'(idx_r) << 1) + XW'(1);
    rch   = (XW'(idx_r) << 1) + XW'(2);
    n_x   = XW'(cnt_r);
    l_win = (lch < n_x) && outranks(rd_a_r, val_r);
    best_v = l_win ? rd_a_r : val_r;
    r_win = (rch < n_x) && outranks(rd_b_r, best_v);
    lch2  = r_win ? (rch << 1) + XW'(1) : (lch << 1) + XW'(1);
    rch2  = lch2 + XW'(1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      H_IDLE: begin
        if (cmd.push && cnt_r != '0) begin
          state_nxt = H_UP;
        end else if (cmd.pop && cnt_r > CW'(1)) begin
          state_nxt = H_LAST;
        end
      end
      H_UP: begin
        if (!outranks(val_r, rd_a_r)) begin
          state_nxt = H_IDLE;
        end else if (par == '0) begin
          state_nxt = H_PUT;
        end
      end
      H_PUT:  state_nxt = H_IDLE;
      H_LAST: state_nxt = H_DOWN;
      H_DOWN: begin
        if (!l_win && !r_win) begin
          state_nxt = H_IDLE;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    pop_nxt   = pop_r;
    rd_a_addr = '0;
    rd_b_addr = '0;
    we        = 1'b0;
    wa        = '0;
    wd        = val_r;
    done      = 1'b0;
    unique case (state_r)
      H_IDLE: begin
        if (cmd.push) begin
          cnt_nxt = cnt_r + CW'(1);
          idx_nxt = AW'(cnt_r);
          val_nxt = cmd_data;
          rd_a_addr = AW'((cnt_r - CW'(1)) >> 1);
          if (cnt_r == '0) begin
            we   = 1'b1;
            wa   = '0;
            wd   = cmd_data;
            done = 1'b1;
          end
        end else if (cmd.pop) begin
          cnt_nxt   = cnt_r - CW'(1);
          pop_nxt   = top_r;
          rd_a_addr = AW'(cnt_r - CW'(1));
          if (cnt_r <= CW'(1)) begin
            done = 1'b1;
          end
        end
      end
      H_UP: begin
        we = 1'b1;
        wa = idx_r;
        if (outranks(val_r, rd_a_r)) begin
          wd        = rd_a_r;
          idx_nxt   = par;
          rd_a_addr = par2;
        end else begin
          wd   = val_r;
          done = 1'b1;
        end
      end
      H_PUT: begin
        we   = 1'b1;
        wa   = idx_r;
        wd   = val_r;
        done = 1'b1;
      end
      H_LAST: begin
        val_nxt   = rd_a_r;
        idx_nxt   = '0;
        rd_a_addr = AW'(1);
        rd_b_addr = AW'(2);
      end
      H_DOWN: begin
        we = 1'b1;
        wa = idx_r;
        if (r_win) begin
          wd      = rd_b_r;
          idx_nxt = rch[AW-1:0];
        end else if (l_win) begin
          wd      = rd_a_r;
          idx_nxt = lch[AW-1:0];
        end else begin
          wd   = val_r;
          done = 1'b1;
        end
        rd_a_addr = lch2[AW-1:0];
        rd_b_addr = rch2[AW-1:0];
      end
      default: ;
    endcase
    top_nxt = (we && wa == '0) ? wd : top_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    top_r <= top_nxt;
    pop_r <= pop_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  assign cnt      = cnt_r;
  assign top      = top_r;
  assign pop_data = pop_r;

endmodule

/* rtl/running_median_two_heaps.sv */
// Top level of the two-heap running median.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | in_sample
//  out_    | output    | out_valid / out_ready | out_median_times_two, out_sample_count,
//          |           |                       | out_dropped
//
// One request at a time. A request takes one push, then possibly a pop plus a push for the
// rebalance, each one memory level per cycle; a dropped sample skips the heaps.
// The sift loops in the two heap memories set how long a request takes.
// Reset (synchronous, rst_n low) empties both heaps; memories are not cleared.
// The result register holds while out_ready is low; a new request is taken meanwhile,
// and its result waits in the controller until the register frees up.
module running_median_two_heaps #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int HEAP_DEPTH   = 512
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [SAMPLE_WIDTH:0] out_median_times_two,
  output logic [10:0]                  out_sample_count,
  output logic                         out_dropped
);
  import rmth_pkg::*;

  localparam int W  = SAMPLE_WIDTH;
  localparam int CW = $clog2(HEAP_DEPTH + 1);

  ctrl_state_t         state_r, state_nxt;
  heap_cmd_t           cmd_lo_r, cmd_lo_nxt, cmd_up_r, cmd_up_nxt;
  logic signed [W-1:0] data_lo_r, data_lo_nxt, data_up_r, data_up_nxt;
  logic                drop_r, drop_nxt;
  logic                mv_lo_r, mv_lo_nxt;   // rebalance moves lower top to upper heap
  logic                out_valid_r, out_valid_nxt;
  logic signed [W:0]   med_r, med_nxt;
  logic [10:0]         scnt_r, scnt_nxt;
  logic                odrop_r;

  logic                lo_done, up_done, hp_done;
  logic [CW-1:0]       lo_cnt, up_cnt;
  logic signed [W-1:0] lo_top, up_top, lo_pop, up_pop;
  logic                to_lo, full, load_out;

  rmth_heap #(.W(W), .DEPTH(HEAP_DEPTH), .IS_MAX(1'b1), .CW(CW)) u_lower (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_lo_r), .cmd_data(data_lo_r),
    .done(lo_done), .cnt(lo_cnt), .top(lo_top), .pop_data(lo_pop)
  );

  rmth_heap #(.W(W), .DEPTH(HEAP_DEPTH), .IS_MAX(1'b0), .CW(CW)) u_upper (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_up_r), .cmd_data(data_up_r),
    .done(up_done), .cnt(up_cnt), .top(up_top), .pop_data(up_pop)
  );

  assign hp_done  = lo_done | up_done;
  // ties with the lower top go up
  assign to_lo    = (lo_cnt == '0) || (in_sample < lo_top);
  assign full     = to_lo ? (lo_cnt == CW'(HEAP_DEPTH)) : (up_cnt == CW'(HEAP_DEPTH));
  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = full ? S_OUT : S_INS;
        end
      end
      S_INS: begin
        if (hp_done) begin
          if (({1'b0, lo_cnt} > ({1'b0, up_cnt} + (CW+1)'(1))) || (lo_cnt < up_cnt)) begin
            state_nxt = S_POP;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_POP:  if (hp_done) state_nxt = S_MOVE;
      S_MOVE: if (hp_done) state_nxt = S_OUT;
      S_OUT:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_lo_nxt    = '0;
    cmd_up_nxt    = '0;
    data_lo_nxt   = data_lo_r;
    data_up_nxt   = data_up_r;
    drop_nxt      = drop_r;
    mv_lo_nxt     = mv_lo_r;
    out_valid_nxt = out_valid_r && !out_ready;
    med_nxt       = med_r;
    scnt_nxt      = scnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          drop_nxt    = full;
          data_lo_nxt = in_sample;
          data_up_nxt = in_sample;
          if (!full) begin
            cmd_lo_nxt.push = to_lo;
            cmd_up_nxt.push = !to_lo;
          end
        end
      end
      S_INS: begin
        if (hp_done) begin
          if ({1'b0, lo_cnt} > ({1'b0, up_cnt} + (CW+1)'(1))) begin
            mv_lo_nxt      = 1'b1;
            cmd_lo_nxt.pop = 1'b1;
          end else if (lo_cnt < up_cnt) begin
            mv_lo_nxt      = 1'b0;
            cmd_up_nxt.pop = 1'b1;
          end
        end
      end
      S_POP: begin
        if (hp_done) begin
          data_lo_nxt     = up_pop;
          data_up_nxt     = lo_pop;
          cmd_up_nxt.push = mv_lo_r;
          cmd_lo_nxt.push = !mv_lo_r;
        end
      end
      S_MOVE: ;
      S_OUT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          scnt_nxt      = 11'({1'b0, lo_cnt} + {1'b0, up_cnt});
          if (lo_cnt == '0) begin
            med_nxt = '0;
          end else if (lo_cnt == up_cnt) begin
            med_nxt = (W+1)'(lo_top) + (W+1)'(up_top);
          end else begin
            med_nxt = {lo_top, 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmd_lo_r    <= '0;
      cmd_up_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_lo_r    <= cmd_lo_nxt;
      cmd_up_r    <= cmd_up_nxt;
      out_valid_r <= out_valid_nxt;
    end
    data_lo_r <= data_lo_nxt;
    data_up_r <= data_up_nxt;
    drop_r    <= drop_nxt;
    mv_lo_r   <= mv_lo_nxt;
    med_r     <= med_nxt;
    scnt_r    <= scnt_nxt;
    if (load_out) begin
      odrop_r <= drop_r;
    end
  end

  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_median_times_two = med_r;
  assign out_sample_count     = scnt_r;
  assign out_dropped          = odrop_r;

endmodule

/* rtl/running_median_two_heaps_checker.sv */
// Port-level checker for the running median, bound to the top level.
`include "running_median_two_heaps_defines.svh"

module running_median_two_heaps_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH:0]   out_median_times_two,
  input logic [10:0]             out_sample_count,
  input logic                    out_dropped
);

  `RMTH_AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_median_times_two) && $stable(out_sample_count), "result changed while stalled")
  `RMTH_AST_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken while busy")
  `RMTH_AST_SAME(a_count_nonzero, out_valid && !out_dropped, out_sample_count != 11'd0, "held count zero after accepted sample")
  `RMTH_AST_RST(a_reset_idle, !rst_n, !out_valid && in_ready, "block not idle after reset")

endmodule

bind running_median_two_heaps running_median_two_heaps_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_median_times_two(out_median_times_two), .out_sample_count(out_sample_count),
  .out_dropped(out_dropped)
);
